// ----- rtl/hcbp_pkg.sv -----
// hcbp_pkg: shared widths, opcodes and table entry type for the huffman code bit packer
// no dependencies; compiled first
package hcbp_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [SYM_W-1:0]  symbol_t;
  typedef logic [LEN_W-1:0]  code_len_t;
  typedef logic [CODE_W-1:0] code_bits_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam opcode_t OP_LOAD   = 2'd0;
  localparam opcode_t OP_ENCODE = 2'd1;
  localparam opcode_t OP_FLUSH  = 2'd2;
  // spare code, the block ignores it
  localparam opcode_t OP_UNUSED = 2'd3;

  // one code table entry as held in the ram
  typedef struct packed {
    code_len_t  len;
    code_bits_t code;
  } entry_t;

endpackage

// ----- rtl/hcbp_in_if.sv -----
// hcbp_in_if: valid/ready channel carrying load, encode and flush transactions
// depends on hcbp_pkg
interface hcbp_in_if;
  logic                   valid;
  logic                   ready;
  hcbp_pkg::opcode_t      opcode;
  hcbp_pkg::symbol_t      symbol;
  hcbp_pkg::code_len_t    code_length;
  hcbp_pkg::code_bits_t   code_bits;

  modport source (output valid, opcode, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, opcode, symbol, code_length, code_bits, output ready);
endinterface

// ----- rtl/hcbp_out_if.sv -----
// hcbp_out_if: valid/ready channel carrying packed output bytes
// depends on hcbp_pkg
interface hcbp_out_if;
  logic            valid;
  logic            ready;
  hcbp_pkg::byte_t out_byte;
  logic            out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ----- rtl/hcbp_ram.sv -----
// hcbp_ram: generic single write port, single read port ram with registered read
// no dependencies
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/huffman_code_bit_packer.sv -----
// huffman_code_bit_packer: top level, code table ram plus the byte packer
// depends on hcbp_pkg, hcbp_in_if, hcbp_out_if and hcbp_ram
//
// usage
//   in_ch carries one transaction per handshake: load writes the code length
//   (saturated to MAX_CODE_LEN) and code bits of one symbol, encode looks the
//   symbol up and appends its code msb first, flush sends any partial byte
//   zero padded with out_last set. out_ch carries one packed byte per
//   transaction, first code bit in bit 7.
//   an encode or flush passes the lookup stage, the packer and the output
//   register before its first byte appears on out_ch.
//   an encode makes the packer complete the pending byte and each further
//   full byte, then merge any bits left over that do not finish a byte into
//   the pending byte; an empty code does not occupy the packer.
//   the packer stage, with its one byte a cycle output while out_ch does not stall, sets the pace;
//   the table read of the next symbol overlaps the current code's packing.
//   a load writes the table and encodes of a just-loaded symbol see the new entry.
//   reset (synchronous) empties the pipeline and clears the pending byte;
//   the table is not cleared and must be loaded before use.
//   a stalled out_ch holds its byte in the output register; the packer and
//   then in_ch stall behind it.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN  = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input logic         clk,
  input logic         rst_n,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);
  import hcbp_pkg::*;

  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam int BUF_W = MAX_CODE_LEN + BYTE_W;
  localparam int SHW   = $clog2(BUF_W + 1);
  localparam int NEED_W = $clog2(BYTE_W + 1);

  // table access
  logic      in_ready;
  logic      in_fire;
  logic      sym_ok;
  logic      ram_we;
  logic      ram_re;
  code_len_t len_sat;
  entry_t    wr_entry;
  entry_t    rd_entry;

  // lookup stage
  logic s1_valid_r, s1_valid_nxt;
  logic s1_flush_r;

  // packer
  logic             busy_r, busy_nxt;
  logic             work_flush_r;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  code_len_t        rem_r, rem_nxt;
  byte_t            pend_r, pend_nxt;
  logic [2:0]       fill_r, fill_nxt;
  logic             take;
  logic             step_done;
  logic             space;
  logic             emit;
  logic             emit_last;
  byte_t            emit_byte;
  byte_t            merged;
  logic [NEED_W-1:0] need;
  code_len_t        need_ext;
  logic [SHW-1:0]   shamt;
  logic [BUF_W+CODE_W-1:0] wide;

  // output register
  logic  out_valid_r;
  byte_t out_byte_r;
  logic  out_last_r;

  assign sym_ok  = {1'b0, in_ch.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign in_ready = !s1_valid_r || take;
  assign in_fire  = in_ch.valid && in_ready;
  assign ram_we   = in_fire && (in_ch.opcode == OP_LOAD) && sym_ok;
  assign ram_re   = in_fire && (in_ch.opcode == OP_ENCODE) && sym_ok;
  assign len_sat  = (in_ch.code_length > LEN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : in_ch.code_length;
  assign wr_entry = '{len: len_sat, code: in_ch.code_bits};

  // a write lands at the edge of its transaction, so a following read sees it
  hcbp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.symbol[AW-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (in_ch.symbol[AW-1:0]),
    .rdata (rd_entry)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = ((in_ch.opcode == OP_ENCODE) && sym_ok) || (in_ch.opcode == OP_FLUSH);
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flush_r <= (in_ch.opcode == OP_FLUSH);
    end
  end

  // packer step: complete a byte, merge leftover bits into the pending byte, or flush it
  assign space    = !out_valid_r || out_ch.ready;
  assign merged   = pend_r | (buf_r[BUF_W-1 -: BYTE_W] >> fill_r);
  assign need     = NEED_W'(BYTE_W) - NEED_W'(fill_r);
  assign need_ext = LEN_W'(need);
  assign shamt    = SHW'(BUF_W) - SHW'(rd_entry.len);
  // left align the code so that its first bit sits at the top of the buffer
  assign wide     = {{BUF_W{1'b0}}, rd_entry.code} << shamt;

  always_comb begin
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    buf_nxt   = buf_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = merged;
    step_done = 1'b0;
    busy_nxt  = busy_r;
    if (busy_r) begin
      if (work_flush_r) begin
        emit_byte = pend_r;
        if (fill_r == 3'd0) begin
          step_done = 1'b1;
        end else if (space) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          pend_nxt  = '0;
          fill_nxt  = '0;
          step_done = 1'b1;
        end
      end else if (rem_r >= need_ext) begin
        if (space) begin
          emit      = 1'b1;
          buf_nxt   = buf_r << need;
          rem_nxt   = rem_r - need_ext;
          pend_nxt  = '0;
          fill_nxt  = '0;
          step_done = (rem_r == need_ext);
        end
      end else begin
        pend_nxt  = merged;
        fill_nxt  = fill_r + rem_r[2:0];
        rem_nxt   = '0;
        step_done = 1'b1;
      end
    end
    take = s1_valid_r && (!busy_r || step_done);
    if (take) begin
      if (s1_flush_r) begin
        busy_nxt = 1'b1;
      end else begin
        buf_nxt  = wide[BUF_W-1:0];
        rem_nxt  = rd_entry.len;
        busy_nxt = (rd_entry.len != '0);
      end
    end else if (step_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= '0;
      fill_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    rem_r <= rem_nxt;
    if (take) begin
      work_flush_r <= s1_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule

// ----- rtl/hcbp_checker.sv -----
// hcbp_sva: port level assertions for the huffman code bit packer
// depends on hcbp_pkg; bound to huffman_code_bit_packer below
module hcbp_sva (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input hcbp_pkg::byte_t out_byte,
  input logic            out_last
);

  // reset leaves no byte on the output
  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an empty lookup stage after reset must accept at once
  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

endmodule

bind huffman_code_bit_packer hcbp_sva u_hcbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);
